>>> rtl/cia_pkg.sv
`timescale 1ns / 1ps

package cia_pkg;

  // overlap case codes
  typedef enum logic [1:0] {
    CASE_DISJOINT  = 2'd0,
    CASE_CONTAINED = 2'd1,
    CASE_LENS      = 2'd2
  } ovl_case_t;

  // normalized operand width, top set bit lands at bit NORM_TOP-1
  localparam int NORM_TOP = 30;
  localparam int NW       = 30;
  localparam int SHW      = 6;

  // fixed-point constants, q30
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  // iteration counts of the division, square root and cordic units
  localparam int DIV_STEPS    = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 31;

  // number of registers along the segment factor pipeline
  localparam int FACTOR_LAT = 6 + DIV_STEPS + SQRT_STEPS + CORDIC_STEPS + 1;

  localparam int OUT_W = 50;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // arctangent of 2^-i in q30 radians
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    unique case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/cia_factor.sv
`timescale 1ns / 1ps

// segment factor t - c*s of one circle from normalized radii and gap
module cia_factor (
  input  logic                    clk,
  input  logic                    en,
  input  logic [cia_pkg::NW-1:0]  a,
  input  logic [cia_pkg::NW-1:0]  b,
  input  logic [cia_pkg::NW-1:0]  g,
  output logic [31:0]             f
);

  localparam int NW   = cia_pkg::NW;
  localparam int PW   = 2 * NW;
  localparam int NUMW = PW + 2;
  localparam int DS   = cia_pkg::DIV_STEPS;
  localparam int SS   = cia_pkg::SQRT_STEPS;
  localparam int CS   = cia_pkg::CORDIC_STEPS;
  localparam int RW   = 62;
  localparam int XW   = 36;
  localparam int ZW   = 34;
  localparam int FW   = 36;

  // products of the normalized operands
  logic [PW-1:0] a2, b2, g2, ag;

  always_ff @(posedge clk) begin
    if (en) begin
      a2 <= PW'(a) * PW'(a);
      b2 <= PW'(b) * PW'(b);
      g2 <= PW'(g) * PW'(g);
      ag <= PW'(a) * PW'(g);
    end
  end

  // numerator, denominator and magnitude
  logic signed [NUMW-1:0] num_c;
  logic [NUMW-1:0]        mag_c, den_c;

  always_comb begin
    num_c = $signed({2'b00, a2}) + $signed({2'b00, g2}) - $signed({2'b00, b2});
    den_c = {1'b0, ag, 1'b0};
    mag_c = num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
  end

  logic [NUMW-1:0] rem  [0:DS];
  logic [NUMW-1:0] den  [0:DS];
  logic [NW-1:0]   quo  [0:DS];
  logic            neg  [0:DS];
  logic            sat  [0:DS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= mag_c;
      den[0] <= den_c;
      quo[0] <= '0;
      neg[0] <= num_c[NUMW-1];
      sat[0] <= (den_c == '0) || (mag_c >= den_c);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [NUMW-1:0] sh;
    logic            ge;
    assign sh = {rem[k][NUMW-2:0], 1'b0};
    assign ge = sh >= den[k];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? sh - den[k] : sh;
        den[k+1] <= den[k];
        quo[k+1] <= {quo[k][NW-2:0], ge};
        neg[k+1] <= neg[k];
        sat[k+1] <= sat[k];
      end
    end
  end

  // signed q30 cosine
  logic signed [31:0] c_c, c_s, c_v;
  logic [31:0]        cmag_c;
  logic [60:0]        cc;
  logic signed [63:0] cc_c;

  assign cmag_c = sat[DS] ? cia_pkg::ONE_Q30 : 32'(quo[DS]);
  assign cc_c   = c_c * c_c;

  always_ff @(posedge clk) begin
    if (en) begin
      c_c <= neg[DS] ? $signed(-cmag_c) : $signed(cmag_c);
      cc  <= cc_c[60:0];
      c_s <= c_c;
    end
  end

  // radicand 1 - c^2
  logic [RW-1:0]      sv [0:SS];
  logic [RW-1:0]      sr [0:SS];
  logic signed [31:0] sc [0:SS];

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= (RW'(1) << 60) - RW'(cc);
      sr[0] <= '0;
      sc[0] <= c_s;
    end
  end

  // integer square root, one result bit per stage
  for (genvar i = 0; i < SS; i++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * i);
    logic [RW-1:0] trial;
    assign trial = sr[i] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[i] >= trial) begin
          sv[i+1] <= sv[i] - trial;
          sr[i+1] <= (sr[i] >> 1) + BIT;
        end else begin
          sv[i+1] <= sv[i];
          sr[i+1] <= sr[i] >> 1;
        end
        sc[i+1] <= sc[i];
      end
    end
  end

  // c*s product and cordic seed
  logic signed [XW-1:0] cx [0:CS];
  logic signed [XW-1:0] cy [0:CS];
  logic signed [ZW-1:0] cz [0:CS];
  logic signed [63:0]   cp [0:CS];
  logic                 cn [0:CS];
  logic [30:0]          s_c;
  logic [31:0]          cabs_c;

  assign s_c    = sr[SS][30:0];
  assign cabs_c = sc[SS][31] ? 32'(-sc[SS]) : 32'(sc[SS]);

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0] <= 64'(sc[SS]) * $signed(64'(s_c));
      cx[0] <= $signed(XW'(cabs_c));
      cy[0] <= $signed(XW'(s_c));
      cz[0] <= '0;
      cn[0] <= sc[SS][31];
    end
  end

  // cordic vectoring, one rotation per stage
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATN = $signed(ZW'(cia_pkg::atan_q30(i)));
    logic signed [XW-1:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATN;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATN;
        end
        cp[i+1] <= cp[i];
        cn[i+1] <= cn[i];
      end
    end
  end

  // angle fold and segment factor clamp
  logic signed [ZW-1:0] t_c;
  logic signed [63:0]   rnd_c;
  logic signed [FW-1:0] ff_c;

  always_comb begin
    t_c   = cn[CS] ? $signed(ZW'(cia_pkg::PI_Q30)) - cz[CS] : cz[CS];
    rnd_c = (cp[CS] + 64'sd536870912) >>> 30;
    ff_c  = FW'(t_c) - FW'(rnd_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ff_c[FW-1]) begin
        f <= '0;
      end else if (ff_c > $signed(FW'(33'h0FFFFFFFF))) begin
        f <= 32'hFFFFFFFF;
      end else begin
        f <= ff_c[31:0];
      end
    end
  end

endmodule

>>> rtl/circle_intersection_area_core.sv
`timescale 1ns / 1ps

// throughput: one item per cycle unless stalled, via a fully pipelined lens datapath
// (30 division stages, 31 square root stages, 31 cordic stages)
// a held result stalls the whole pipeline until it transfers
// reset clears every valid bit; payload registers are not reset
module circle_intersection_area_core #(
  parameter int IN_WIDTH  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [IN_WIDTH-1:0]        radius_a,
  input  logic [IN_WIDTH-1:0]        radius_b,
  input  logic [IN_WIDTH-1:0]        center_gap,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cia_pkg::OUT_W-1:0]  overlap_area,
  output logic [1:0]                 overlap_case
);

  localparam int NW    = cia_pkg::NW;
  localparam int SHW   = cia_pkg::SHW;
  localparam int SQW   = 2 * IN_WIDTH;
  localparam int EW    = IN_WIDTH + cia_pkg::NORM_TOP;
  localparam int LAT   = cia_pkg::FACTOR_LAT;
  localparam int OUT_W = cia_pkg::OUT_W + FRAC_BITS - FRAC_BITS;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input register
  logic                v0;
  logic [IN_WIDTH-1:0] ra0, rb0, g0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra0 <= radius_a;
      rb0 <= radius_b;
      g0  <= center_gap;
    end
  end

  // case decision and normalizing shift
  logic [IN_WIDTH-1:0]   lo_c, hi_c, m_c;
  logic [IN_WIDTH:0]     rsum_c, lsum_c;
  logic [SHW-1:0]        len_c, lsh_c, rsh_c;
  cia_pkg::ovl_case_t    code_c;

  always_comb begin
    lo_c   = (ra0 < rb0) ? ra0 : rb0;
    hi_c   = (ra0 < rb0) ? rb0 : ra0;
    m_c    = (hi_c > g0) ? hi_c : g0;
    rsum_c = (IN_WIDTH+1)'(ra0) + (IN_WIDTH+1)'(rb0);
    lsum_c = (IN_WIDTH+1)'(lo_c) + (IN_WIDTH+1)'(g0);
    len_c  = '0;
    for (int i = 0; i < IN_WIDTH; i++) begin
      if (m_c[i]) begin
        len_c = SHW'(i + 1);
      end
    end
    lsh_c = '0;
    rsh_c = '0;
    if (len_c < SHW'(cia_pkg::NORM_TOP)) begin
      lsh_c = SHW'(cia_pkg::NORM_TOP) - len_c;
    end else begin
      rsh_c = len_c - SHW'(cia_pkg::NORM_TOP);
    end
    priority if ((IN_WIDTH+1)'(g0) >= rsum_c) begin
      code_c = cia_pkg::CASE_DISJOINT;
    end else if (lsum_c <= (IN_WIDTH+1)'(hi_c)) begin
      code_c = cia_pkg::CASE_CONTAINED;
    end else begin
      code_c = cia_pkg::CASE_LENS;
    end
  end

  logic                v1;
  logic [IN_WIDTH-1:0] ra1, rb1, g1, lo1;
  logic [SHW-1:0]      lsh1, rsh1;
  cia_pkg::ovl_case_t  code1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra1   <= ra0;
      rb1   <= rb0;
      g1    <= g0;
      lo1   <= lo_c;
      lsh1  <= lsh_c;
      rsh1  <= rsh_c;
      code1 <= code_c;
    end
  end

  // normalize and square the raw radii
  logic               v2;
  logic [NW-1:0]      na2, nb2, ng2;
  logic [SQW-1:0]     sqa2, sqb2;
  cia_pkg::ovl_case_t code2;
  logic [EW-1:0]      ea_c, eb_c, eg_c;
  logic [IN_WIDTH-1:0] sqsel_c;

  always_comb begin
    ea_c    = (EW'(ra1) << lsh1) >> rsh1;
    eb_c    = (EW'(rb1) << lsh1) >> rsh1;
    eg_c    = (EW'(g1) << lsh1) >> rsh1;
    sqsel_c = (code1 == cia_pkg::CASE_CONTAINED) ? lo1 : ra1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na2   <= ea_c[NW-1:0];
      nb2   <= eb_c[NW-1:0];
      ng2   <= eg_c[NW-1:0];
      sqa2  <= SQW'(sqsel_c) * SQW'(sqsel_c);
      sqb2  <= SQW'(rb1) * SQW'(rb1);
      code2 <= code1;
    end
  end

  // segment factors of both circles
  logic [31:0] fa, fb;

  cia_factor u_factor_a (
    .clk (clk),
    .en  (en),
    .a   (na2),
    .b   (nb2),
    .g   (ng2),
    .f   (fa)
  );

  cia_factor u_factor_b (
    .clk (clk),
    .en  (en),
    .a   (nb2),
    .b   (na2),
    .g   (ng2),
    .f   (fb)
  );

  // side line that travels with the factor pipeline
  logic               dv    [0:LAT-1];
  cia_pkg::ovl_case_t dcode [0:LAT-1];
  logic [SQW-1:0]     dsqa  [0:LAT-1];
  logic [SQW-1:0]     dsqb  [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v2;
      for (int k = 1; k < LAT; k++) begin
        dv[k] <= dv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcode[0] <= code2;
      dsqa[0]  <= sqa2;
      dsqb[0]  <= sqb2;
      for (int k = 1; k < LAT; k++) begin
        dcode[k] <= dcode[k-1];
        dsqa[k]  <= dsqa[k-1];
        dsqb[k]  <= dsqb[k-1];
      end
    end
  end

  // factor select: contained case scales the smaller square by pi
  logic               v3;
  cia_pkg::ovl_case_t code3;
  logic [63:0]        sqa3, sqb3;
  logic [31:0]        ka3, kb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= dv[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code3 <= dcode[LAT-1];
      sqa3  <= 64'(dsqa[LAT-1]);
      sqb3  <= 64'(dsqb[LAT-1]);
      if (dcode[LAT-1] == cia_pkg::CASE_CONTAINED) begin
        ka3 <= cia_pkg::PI_Q30;
        kb3 <= '0;
      end else begin
        ka3 <= fa;
        kb3 <= fb;
      end
    end
  end

  // low partial products with rounding bias
  logic               v4;
  cia_pkg::ovl_case_t code4;
  logic [63:0]        loa4, lob4;
  logic [31:0]        sha4, shb4, ka4, kb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code4 <= code3;
      loa4  <= 64'(sqa3[31:0]) * 64'(ka3) + (64'(1) << 29);
      lob4  <= 64'(sqb3[31:0]) * 64'(kb3) + (64'(1) << 29);
      sha4  <= sqa3[63:32];
      shb4  <= sqb3[63:32];
      ka4   <= ka3;
      kb4   <= kb3;
    end
  end

  // high partial products
  logic               v5;
  cia_pkg::ovl_case_t code5;
  logic [63:0]        loa5, lob5, hia5, hib5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code5 <= code4;
      loa5  <= loa4;
      lob5  <= lob4;
      hia5  <= 64'(sha4) * 64'(ka4);
      hib5  <= 64'(shb4) * 64'(kb4);
    end
  end

  // per-circle terms, saturated
  localparam logic [63:0] HI_LIM = 64'(cia_pkg::OUT_MAX) >> 2;

  function automatic logic [OUT_W-1:0] term_sat(input logic [63:0] lo, input logic [63:0] hi);
    logic [OUT_W+1:0] r;
    r = (OUT_W+2)'(hi[OUT_W-3:0]) * (OUT_W+2)'(4) + (OUT_W+2)'(lo >> 30);
    if (hi > HI_LIM || r > (OUT_W+2)'(cia_pkg::OUT_MAX)) begin
      return cia_pkg::OUT_MAX;
    end
    return r[OUT_W-1:0];
  endfunction

  logic               v6;
  cia_pkg::ovl_case_t code6;
  logic [OUT_W-1:0]   ta6, tb6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code6 <= code5;
      ta6   <= term_sat(loa5, hia5);
      tb6   <= term_sat(lob5, hib5);
    end
  end

  // sum, saturation and output register
  logic [OUT_W:0] sum_c;
  assign sum_c = (OUT_W+1)'(ta6) + (OUT_W+1)'(tb6);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_case <= code6;
      unique case (code6)
        cia_pkg::CASE_DISJOINT: overlap_area <= '0;
        cia_pkg::CASE_CONTAINED, cia_pkg::CASE_LENS: begin
          overlap_area <= sum_c[OUT_W] ? cia_pkg::OUT_MAX : sum_c[OUT_W-1:0];
        end
        default: overlap_area <= '0;
      endcase
    end
  end

  // disjoint circles never report area
  a_disjoint_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && overlap_case == cia_pkg::CASE_DISJOINT |-> overlap_area == '0)
    else $error("disjoint result with nonzero area");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // the last stage moves into the output whenever the pipeline advances
  a_drain: assert property (@(posedge clk) disable iff (rst)
    v6 && en |=> out_valid)
    else $error("pipeline item lost at output");

  // the contained case always scales by pi with a zero second factor
  a_contained_factor: assert property (@(posedge clk) disable iff (rst)
    v3 && code3 == cia_pkg::CASE_CONTAINED |-> ka3 == cia_pkg::PI_Q30 && kb3 == '0)
    else $error("contained case factor wrong");

endmodule
